FILE: rtl/antialiased_line_plotter_macros.svh
// Assertion macros used by antialiased_line_plotter.sv. Both assume a clock named clk_i
// and an active-low reset named rst_ni in the module that uses them.
`ifndef ANTIALIASED_LINE_PLOTTER_MACROS_SVH
`define ANTIALIASED_LINE_PLOTTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define APL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

`define APL_NEVER(lbl, cond) \
  `APL_ASSERT(lbl, !(cond))

`else

`define APL_ASSERT(lbl, prop)

`define APL_NEVER(lbl, cond)

`endif

`endif

FILE: rtl/apl_pkg.sv
package apl_pkg;

  localparam int unsigned FbWidthDef       = 256;
  localparam int unsigned FbHeightDef      = 256;
  localparam int unsigned CoordFracBitsDef = 4;

  // Q.16 fixed point one.
  localparam logic [16:0] Q16One = 17'h10000;

  // Number of steps of the restoring divider: a 17-bit magnitude shifted up by 16.
  localparam int unsigned DivSteps = 33;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_RDWAIT = 13'b0000000000100,
    S_SETUP  = 13'b0000000001000,
    S_ORDER  = 13'b0000000010000,
    S_DIV    = 13'b0000000100000,
    S_GRAD   = 13'b0000001000000,
    S_END    = 13'b0000010000000,
    S_ENDB   = 13'b0000100000000,
    S_PMUL   = 13'b0001000000000,
    S_PRD    = 13'b0010000000000,
    S_PWR    = 13'b0100000000000,
    S_MID    = 13'b1000000000000
  } state_e;

  typedef enum logic [1:0] {
    SEG_END1 = 2'd0,
    SEG_END2 = 2'd1,
    SEG_MID  = 2'd2
  } seg_e;

  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_READ = 1'b1;

endpackage

FILE: rtl/apl_ram.sv
module apl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/antialiased_line_plotter.sv
// Antialiased line plotter (Wu's method) over a gray frame store of
// FB_WIDTH x FB_HEIGHT bytes held in one single-port-write, registered-read
// RAM. After reset a clearing pass writes zero to every entry, one per cycle;
// no request is accepted until it ends. A read request's result is loaded
// from the RAM in the wait state, once the output register is free, and is
// held there until it is accepted. A draw request first sets up the line,
// with a 33-step serial divider for the gradient (skipped when dx is zero),
// then plots each pixel by a read-modify-write of the frame store (multiply,
// read and write states): both endpoint pairs first, then two pixels per
// column between them, stepping column by column.
// One request is worked on at a time; a pending result does not block a draw.
`include "antialiased_line_plotter_macros.svh"

module antialiased_line_plotter #(
  parameter int unsigned FB_WIDTH        = apl_pkg::FbWidthDef,
  parameter int unsigned FB_HEIGHT       = apl_pkg::FbHeightDef,
  parameter int unsigned COORD_FRAC_BITS = apl_pkg::CoordFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic signed [15:0] line_x0_i,
  input  logic signed [15:0] line_y0_i,
  input  logic signed [15:0] line_x1_i,
  input  logic signed [15:0] line_y1_i,
  input  logic [7:0]         read_col_i,
  input  logic [7:0]         read_row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         pixel_value_o
);

  import apl_pkg::*;

  localparam int unsigned Depth = FB_WIDTH * FB_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CLW   = $clog2(FB_WIDTH);
  localparam int unsigned RWW   = $clog2(FB_HEIGHT);
  localparam int unsigned Half  = (1 << COORD_FRAC_BITS) >> 1;
  localparam int unsigned Shl   = 16 - COORD_FRAC_BITS;
  localparam int unsigned PW    = 19;  // pixel coordinates, signed
  localparam int unsigned YW    = 36;  // Q.16 y values, signed

  state_e state_q, state_d;
  seg_e   seg_q;

  logic signed [15:0] x0_q, y0_q, x1_q, y1_q;
  logic               steep_q;
  logic [16:0]        div_den_q;
  logic [17:0]        div_rem_q;
  logic [32:0]        div_num_q;
  logic [5:0]         div_cnt_q;
  logic               dy_neg_q;
  logic signed [17:0] grad_q;
  logic signed [PW-1:0] xe_q, xp1_q, xp2_q, plot_x_q;
  logic signed [19:0] dlt_q;
  logic [16:0]        gap_q;
  logic signed [YW-1:0] intery_q, plot_yq_q;
  logic               half_q;
  logic [33:0]        prod_q;
  logic signed [PW-1:0] col_q, row_q;
  logic               inr_q;
  logic [7:0]         val_q;
  logic [AW-1:0]      addr_q, clr_q;
  logic               rd_oob_q;
  logic               out_valid_q;
  logic [7:0]         pixel_q;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic accept;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Read request address and range check.
  logic          rd_inr;
  logic [AW-1:0] rd_addr;
  assign rd_inr  = ({5'd0, read_col_i} < 13'(FB_WIDTH)) && ({5'd0, read_row_i} < 13'(FB_HEIGHT));
  assign rd_addr = AW'(AW'(read_row_i) * AW'(FB_WIDTH) + AW'(read_col_i));

  // Axis swap for steep lines.
  logic signed [16:0] sd_x, sd_y;
  logic [16:0]        adx, ady;
  logic               steep;
  assign sd_x  = 17'(x1_q) - 17'(x0_q);
  assign sd_y  = 17'(y1_q) - 17'(y0_q);
  assign adx   = sd_x[16] ? 17'(-sd_x) : 17'(sd_x);
  assign ady   = sd_y[16] ? 17'(-sd_y) : 17'(sd_y);
  assign steep = ady > adx;

  // Endpoint ordering.
  logic               swap;
  logic signed [15:0] ox0, oy0, ox1, oy1;
  logic signed [16:0] dx, dy;
  logic [16:0]        dy_mag;
  assign swap   = x0_q > x1_q;
  assign ox0    = swap ? x1_q : x0_q;
  assign oy0    = swap ? y1_q : y0_q;
  assign ox1    = swap ? x0_q : x1_q;
  assign oy1    = swap ? y0_q : y1_q;
  assign dx     = 17'(ox1) - 17'(ox0);
  assign dy     = 17'(oy1) - 17'(oy0);
  assign dy_mag = dy[16] ? 17'(-dy) : 17'(dy);

  // Divider step.
  logic [17:0] div_r;
  logic        div_ge;
  assign div_r  = {div_rem_q[16:0], div_num_q[32]};
  assign div_ge = div_r >= {1'b0, div_den_q};

  logic [16:0] div_q;
  assign div_q = div_num_q[16:0];

  // Endpoint set-up: rounding, offset and gap.
  logic signed [15:0] ex, ey;
  logic signed [17:0] exw, ex_pos, ex_neg, xp;
  logic signed [19:0] dlt;
  logic signed [31:0] ex_sh;
  logic [15:0]        fr;
  logic [16:0]        gap;
  assign ex     = (seg_q == SEG_END1) ? x0_q : x1_q;
  assign ey     = (seg_q == SEG_END1) ? y0_q : y1_q;
  assign exw    = 18'(ex);
  assign ex_pos = (exw + 18'(Half)) >>> COORD_FRAC_BITS;
  assign ex_neg = 18'(-((18'(-exw) + 18'(Half)) >>> COORD_FRAC_BITS));
  assign xp     = ex[15] ? ex_neg : ex_pos;
  assign dlt    = (20'(xp) <<< COORD_FRAC_BITS) - 20'(exw);
  assign ex_sh  = 32'(ex) <<< Shl;
  assign fr     = ex_sh[15:0] + 16'h8000;
  assign gap    = (seg_q == SEG_END1) ? 17'(Q16One - {1'b0, fr}) : {1'b0, fr};

  logic signed [37:0]   eprod;
  logic signed [YW-1:0] yend;
  assign eprod = grad_q * dlt_q;
  assign yend  = (YW'(ey) <<< Shl) + YW'(eprod >>> COORD_FRAC_BITS);

  // Pixel of the current plot.
  logic [15:0]          pf;
  logic signed [PW-1:0] py, pcol, prow;
  logic [16:0]          pa;
  logic                 pinr;
  assign pf   = plot_yq_q[15:0];
  assign py   = PW'(plot_yq_q >>> 16) + PW'(half_q);
  assign pcol = steep_q ? py : plot_x_q;
  assign prow = steep_q ? plot_x_q : py;
  assign pa   = half_q ? {1'b0, pf} : 17'(Q16One - {1'b0, pf});
  assign pinr = (pcol >= 0) && (pcol < $signed(PW'(FB_WIDTH))) &&
                (prow >= 0) && (prow < $signed(PW'(FB_HEIGHT)));

  logic [41:0]   p255;
  logic [AW-1:0] paddr;
  assign p255  = ({8'd0, prod_q} << 8) - {8'd0, prod_q};
  assign paddr = AW'(AW'(row_q[RWW-1:0]) * AW'(FB_WIDTH) + AW'(col_q[CLW-1:0]));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_q == AW'(Depth - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) state_d = (req_type_i == REQ_READ) ? S_RDWAIT : S_SETUP;
      end
      S_RDWAIT: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      S_SETUP:  state_d = S_ORDER;
      S_ORDER:  state_d = (dx == 17'd0) ? S_END : S_DIV;
      S_DIV:    if (div_cnt_q == 6'd1) state_d = S_GRAD;
      S_GRAD:   state_d = S_END;
      S_END:    state_d = S_ENDB;
      S_ENDB:   state_d = S_PMUL;
      S_PMUL:   state_d = S_PRD;
      S_PRD:    state_d = S_PWR;
      S_PWR: begin
        if (!half_q) state_d = S_PMUL;
        else if (seg_q == SEG_END1) state_d = S_END;
        else state_d = S_MID;
      end
      S_MID:    state_d = (plot_x_q < xp2_q) ? S_PMUL : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == S_RDWAIT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          x0_q     <= line_x0_i;
          y0_q     <= line_y0_i;
          x1_q     <= line_x1_i;
          y1_q     <= line_y1_i;
          rd_oob_q <= !rd_inr;
        end
      end
      S_RDWAIT: begin
        if (!out_valid_q || out_ready_i) pixel_q <= rd_oob_q ? 8'd0 : ram_rdata;
      end
      S_SETUP: begin
        steep_q <= steep;
        if (steep) begin
          x0_q <= y0_q;
          y0_q <= x0_q;
          x1_q <= y1_q;
          y1_q <= x1_q;
        end
      end
      S_ORDER: begin
        x0_q      <= ox0;
        y0_q      <= oy0;
        x1_q      <= ox1;
        y1_q      <= oy1;
        seg_q     <= SEG_END1;
        grad_q    <= 18'(Q16One);
        dy_neg_q  <= dy[16];
        div_den_q <= 17'(dx);
        div_rem_q <= '0;
        div_num_q <= {dy_mag, 16'd0};
        div_cnt_q <= 6'(DivSteps);
      end
      S_DIV: begin
        div_rem_q <= div_ge ? 18'(div_r - {1'b0, div_den_q}) : div_r;
        div_num_q <= {div_num_q[31:0], div_ge};
        div_cnt_q <= div_cnt_q - 6'd1;
      end
      S_GRAD: begin
        grad_q <= dy_neg_q ? 18'(-$signed({1'b0, div_q})) : $signed({1'b0, div_q});
      end
      S_END: begin
        xe_q  <= PW'(xp);
        dlt_q <= dlt;
        gap_q <= gap;
      end
      S_ENDB: begin
        plot_x_q  <= xe_q;
        plot_yq_q <= yend;
        half_q    <= 1'b0;
        if (seg_q == SEG_END1) begin
          xp1_q    <= xe_q;
          intery_q <= yend + YW'(grad_q);
        end else begin
          xp2_q <= xe_q;
        end
      end
      S_PMUL: begin
        prod_q <= pa * gap_q;
        col_q  <= pcol;
        row_q  <= prow;
        inr_q  <= pinr;
      end
      S_PRD: begin
        val_q  <= p255[39:32];
        addr_q <= paddr;
      end
      S_PWR: begin
        half_q <= ~half_q;
        if (half_q) begin
          case (seg_q)
            SEG_END1: seg_q <= SEG_END2;
            SEG_END2: begin
              seg_q    <= SEG_MID;
              plot_x_q <= xp1_q + PW'(1);
            end
            default: begin
              plot_x_q <= plot_x_q + PW'(1);
              intery_q <= intery_q + YW'(grad_q);
            end
          endcase
        end
      end
      S_MID: begin
        plot_yq_q <= intery_q;
        gap_q     <= Q16One;
        half_q    <= 1'b0;
      end
      default: ;
    endcase
  end

  // Only one pixel is in flight, so a read always sees the previous write.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = val_q;
    ram_re    = 1'b0;
    ram_raddr = paddr;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'd0;
      end
      S_IDLE: begin
        ram_re    = accept && (req_type_i == REQ_READ);
        ram_raddr = rd_addr;
      end
      S_PRD:   ram_re = inr_q;
      S_PWR:   ram_we = inr_q && (val_q > ram_rdata);
      default: ;
    endcase
  end

  apl_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_q;

  `APL_ASSERT(a_div_rem_bound, (state_q == S_DIV) |-> (div_rem_q < {1'b0, div_den_q}))
  `APL_ASSERT(a_plot_seq, (state_q == S_PMUL) |=> (state_q == S_PRD) ##1 (state_q == S_PWR))
  `APL_ASSERT(a_grad_range, (state_q == S_END) |-> (grad_q <= 18'sd65536 && grad_q >= -18'sd65536))
  `APL_NEVER(a_no_write_in_read, (state_q == S_RDWAIT || state_q == S_IDLE) && ram_we)
  `APL_ASSERT(a_clear_done, $fell(state_q == S_CLEAR) |-> ($past(clr_q) == AW'(Depth - 1)))

endmodule
